FILE: src/assert_macros.svh
// Assertion macros for the file that carries checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge while reset is low.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every rising edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: src/wrpa_pkg.sv
`default_nettype none

package wrpa_pkg;

  localparam int unsigned MUL_W = 32;
  localparam int unsigned DIV_W = 48;
  localparam int unsigned REM_W = 32;

  localparam logic [31:0] FIX_ONE = 32'd65536;
  localparam logic [31:0] DUR_RESET = 32'd65536;

  localparam logic [1:0] KIND_BLEND = 2'd0;
  localparam logic [1:0] KIND_ASYNC = 2'd1;
  localparam logic [1:0] KIND_TICK  = 2'd2;

  typedef struct packed {
    logic [1:0]         kind;
    logic [15:0]        target_weight_in;
    logic [31:0]        ramp_delay;
    logic [31:0]        unlink_time;
    logic [31:0]        mixer_duration;
    logic signed [31:0] delta_time;
  } in_word_t;

  typedef struct packed {
    logic        still_active;
    logic [15:0] current_weight;
    logic [31:0] cycle_phase;
    logic        async_mode;
  } out_word_t;

endpackage

`default_nettype wire

FILE: src/wrpa_mul.sv
`default_nettype none

module wrpa_mul
  import wrpa_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  input  wire logic [MUL_W-1:0]     a,
  input  wire logic [MUL_W-1:0]     b,
  output logic                      done,
  output logic [2*MUL_W-1:0]        product
);

  localparam int unsigned CNT_W = $clog2(MUL_W);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(MUL_W - 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [MUL_W-1:0] a_reg;
  logic [MUL_W:0]   sum;

  // One multiplier bit per cycle, least significant first.
  always_comb begin
    sum = {1'b0, product[2*MUL_W-1:MUL_W]} + (product[0] ? {1'b0, a_reg} : '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_reg   <= a;
      product <= {{MUL_W{1'b0}}, b};
    end else if (busy) begin
      product <= {sum, product[MUL_W-1:1]};
    end
  end

endmodule

`default_nettype wire

FILE: src/wrpa_div.sv
`default_nettype none

module wrpa_div
  import wrpa_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [DIV_W-1:0]  dividend,
  input  wire logic [REM_W-1:0]  divisor,
  output logic                   done,
  output logic [DIV_W-1:0]       quotient,
  output logic [REM_W-1:0]       remainder
);

  localparam int unsigned CNT_W = $clog2(DIV_W);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(DIV_W - 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [REM_W-1:0] dsr;
  logic [REM_W:0]   trial;
  logic [REM_W:0]   diff;
  logic             fits;

  // Restoring division, one quotient bit per cycle. The dividend shifts
  // out of the top of the quotient register as quotient bits enter below.
  always_comb begin
    trial = {remainder, quotient[DIV_W-1]};
    diff  = trial - {1'b0, dsr};
    fits  = (trial >= {1'b0, dsr});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dsr       <= divisor;
      quotient  <= dividend;
      remainder <= '0;
    end else if (busy) begin
      remainder <= fits ? diff[REM_W-1:0] : trial[REM_W-1:0];
      quotient  <= {quotient[DIV_W-2:0], fits};
    end
  end

endmodule

`default_nettype wire

FILE: src/weight_ramp_phase_accumulator.sv
// Blend weight ramp and cycle phase accumulator. Each word on the input
// channel (blend, go-async, tick or an unused kind) yields exactly one word
// on the output channel reporting the state after it. animation_duration is
// written through cfg_we/cfg_wdata; the user must write it only while the
// block is idle, as the block itself does not enforce this. Words are
// processed one at a time, and a result may wait for out_ready before the
// next word is accepted. The work is done by the shared shift-add multiplier
// (one bit per cycle) and the shared restoring divider (one quotient bit per
// cycle); a tick may use each of them twice for the weight step, the phase
// step and the wrap.
`default_nettype none
`include "assert_macros.svh"

module weight_ramp_phase_accumulator
  import wrpa_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire in_word_t    in_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output out_word_t        out_data,
  input  wire logic        cfg_we,
  input  wire logic [31:0] cfg_wdata
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_FDIV,
    S_FMUL,
    S_WMUL,
    S_WDIV,
    S_PMUL,
    S_WRAP,
    S_PDIV,
    S_DONE
  } state_t;

  state_t   state;
  in_word_t item;

  logic [31:0] animation_duration;
  logic [15:0] weight_now;
  logic [15:0] weight_goal;
  logic [31:0] delay_left;
  logic [31:0] phase_time;
  logic [31:0] speed_factor;
  logic        is_async;
  logic        active;

  logic              mul_start;
  logic [MUL_W-1:0]  mul_a;
  logic [MUL_W-1:0]  mul_b;
  logic              mul_done;
  logic [2*MUL_W-1:0] mul_prod;

  logic              div_start;
  logic [DIV_W-1:0]  div_dividend;
  logic [REM_W-1:0]  div_divisor;
  logic              div_done;
  logic [DIV_W-1:0]  div_quot;
  logic [REM_W-1:0]  div_rem;

  logic [31:0] d_bits;
  logic        d_neg;
  logic [31:0] mag;
  logic        settle;
  logic [16:0] diff17;
  logic [15:0] diff_mag;
  logic        step_neg;
  logic [17:0] w18;
  logic [15:0] weight_next;
  logic [32:0] dl_sum;
  logic [31:0] delay_next;
  logic [31:0] factor_sat;
  logic [31:0] phase_async;
  logic [47:0] step48;
  logic [48:0] add49;
  logic [31:0] phase_next;

  wrpa_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .a       (mul_a),
    .b       (mul_b),
    .done    (mul_done),
    .product (mul_prod)
  );

  wrpa_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .done      (div_done),
    .quotient  (div_quot),
    .remainder (div_rem)
  );

  assign in_ready = (state == S_IDLE);

  always_comb begin
    d_bits   = item.delta_time;
    d_neg    = d_bits[31];
    mag      = d_neg ? (~d_bits + 32'd1) : d_bits;
    settle   = (delay_left <= mag);
    diff17   = {1'b0, weight_goal} - {1'b0, weight_now};
    diff_mag = diff17[16] ? (~diff17[15:0] + 16'd1) : diff17[15:0];
    step_neg = d_neg ^ diff17[16];
    w18      = {2'b00, weight_now} + (step_neg ? (~{2'b00, div_quot[15:0]} + 18'd1)
                                               : {2'b00, div_quot[15:0]});
    if (w18[17]) begin
      weight_next = '0;
    end else if (w18[16]) begin
      weight_next = '1;
    end else begin
      weight_next = w18[15:0];
    end
    dl_sum = {1'b0, delay_left} + {1'b0, mag};
    if (d_neg) begin
      delay_next = dl_sum[32] ? '1 : dl_sum[31:0];
    end else begin
      delay_next = delay_left - mag;
    end
    factor_sat  = (|div_quot[47:32]) ? '1 : div_quot[31:0];
    phase_async = (|mul_prod[63:48]) ? '1 : mul_prod[47:16];
    step48      = mul_prod[63:16];
    add49       = {17'd0, phase_time} + {1'b0, step48};
    if (d_neg) begin
      phase_next = (step48 >= {16'd0, phase_time}) ? '0 : (phase_time - step48[31:0]);
    end else begin
      phase_next = (|add49[48:32]) ? '1 : add49[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= S_IDLE;
      animation_duration <= DUR_RESET;
      weight_now         <= '0;
      weight_goal        <= '0;
      delay_left         <= '0;
      phase_time         <= '0;
      speed_factor       <= FIX_ONE;
      is_async           <= 1'b0;
      active             <= 1'b1;
      mul_start          <= 1'b0;
      div_start          <= 1'b0;
      out_valid          <= 1'b0;
    end else begin
      if (mul_start) begin
        mul_start <= 1'b0;
      end
      if (div_start) begin
        div_start <= 1'b0;
      end
      if (cfg_we) begin
        animation_duration <= cfg_wdata;
      end
      if (out_valid && out_ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            item   <= in_data;
            active <= 1'b1;
            state  <= S_DISPATCH;
          end
        end
        S_DISPATCH: begin
          unique case (item.kind)
            KIND_BLEND: begin
              weight_goal <= item.target_weight_in;
              delay_left  <= item.ramp_delay;
              state       <= S_DONE;
            end
            KIND_ASYNC: begin
              if (is_async) begin
                state <= S_DONE;
              end else if (item.mixer_duration == '0) begin
                speed_factor <= FIX_ONE;
                phase_time   <= '0;
                is_async     <= 1'b1;
                state        <= S_DONE;
              end else begin
                div_dividend <= {animation_duration, 16'd0};
                div_divisor  <= item.mixer_duration;
                div_start    <= 1'b1;
                state        <= S_FDIV;
              end
            end
            KIND_TICK: begin
              if (settle) begin
                weight_now <= weight_goal;
                delay_left <= '0;
                if (weight_goal == '0) begin
                  active <= 1'b0;
                  state  <= S_DONE;
                end else if (is_async) begin
                  mul_a     <= mag;
                  mul_b     <= speed_factor;
                  mul_start <= 1'b1;
                  state     <= S_PMUL;
                end else begin
                  state <= S_DONE;
                end
              end else begin
                mul_a     <= mag;
                mul_b     <= {16'd0, diff_mag};
                mul_start <= 1'b1;
                state     <= S_WMUL;
              end
            end
            default: begin
              state <= S_DONE;
            end
          endcase
        end
        S_FDIV: begin
          if (div_done) begin
            speed_factor <= factor_sat;
            mul_a        <= item.unlink_time;
            mul_b        <= factor_sat;
            mul_start    <= 1'b1;
            state        <= S_FMUL;
          end
        end
        S_FMUL: begin
          if (mul_done) begin
            phase_time <= phase_async;
            is_async   <= 1'b1;
            state      <= S_DONE;
          end
        end
        S_WMUL: begin
          if (mul_done) begin
            div_dividend <= mul_prod[DIV_W-1:0];
            div_divisor  <= delay_left;
            div_start    <= 1'b1;
            state        <= S_WDIV;
          end
        end
        S_WDIV: begin
          if (div_done) begin
            weight_now <= weight_next;
            delay_left <= delay_next;
            if (is_async) begin
              mul_a     <= mag;
              mul_b     <= speed_factor;
              mul_start <= 1'b1;
              state     <= S_PMUL;
            end else begin
              state <= S_DONE;
            end
          end
        end
        S_PMUL: begin
          if (mul_done) begin
            phase_time <= phase_next;
            state      <= S_WRAP;
          end
        end
        S_WRAP: begin
          if (phase_time < animation_duration) begin
            state <= S_DONE;
          end else if (animation_duration == '0) begin
            phase_time <= '0;
            state      <= S_DONE;
          end else begin
            div_dividend <= {16'd0, phase_time};
            div_divisor  <= animation_duration;
            div_start    <= 1'b1;
            state        <= S_PDIV;
          end
        end
        S_PDIV: begin
          if (div_done) begin
            phase_time <= div_rem;
            state      <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid               <= 1'b1;
            out_data.still_active   <= active;
            out_data.current_weight <= weight_now;
            out_data.cycle_phase    <= phase_time;
            out_data.async_mode     <= is_async;
            state                   <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `ASSERT_CLK(a_one_word_at_a_time, clk, rst,
              (in_valid && in_ready) |=> !in_ready,
              "word accepted while another is in flight")
  `ASSERT_CLK(a_async_sticks, clk, rst, is_async |=> is_async,
              "asynchronous mode cleared without reset")
  `ASSERT_CLK(a_factor_sync, clk, rst,
              (in_ready && !is_async) |-> (speed_factor == FIX_ONE),
              "speed factor changed before going asynchronous")
  `ASSERT_CLK(a_mul_owner, clk, rst,
              mul_done |-> (state == S_FMUL || state == S_WMUL || state == S_PMUL),
              "multiplier finished with no step waiting on it")

endmodule

`default_nettype wire

FILE: tb/weight_ramp_phase_accumulator_tb.sv
`timescale 1ns / 100ps

module weight_ramp_phase_accumulator_tb;
  import wrpa_pkg::*;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int STALL_LIMIT = 5000;
  localparam int PHASE_COUNT = 8;
  localparam int WORDS_PER_PHASE = 200;

  typedef struct {
    bit          set_cfg;
    logic [31:0] cfg_value;
    in_word_t    word;
    bit          typed;
    out_word_t   want;
  } drill_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_word_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_word_t   out_data;
  logic        cfg_we = 1'b0;
  logic [31:0] cfg_wdata = '0;

  logic [15:0] model_weight = '0;
  logic [15:0] model_goal = '0;
  logic [31:0] model_delay = '0;
  logic [31:0] model_phase = '0;
  logic [31:0] model_speed = FIX_ONE;
  logic [31:0] model_duration = DUR_RESET;
  logic        model_async = 1'b0;

  out_word_t   expected_reports[$];
  drill_row_t  drills[$];
  int          fault_count = 0;
  int          idle_cycles = 0;
  int          send_idle_pct = 0;
  int          stall_pct = 0;

  weight_ramp_phase_accumulator i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void flag_fault(string msg);
    if (fault_count < 10) begin
      $display("%0t: %s", $time, msg);
    end
    fault_count++;
  endfunction

  function automatic logic [31:0] clip32(logic [63:0] v);
    return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
  endfunction

  function automatic out_word_t blend_phase_step(in_word_t w);
    out_word_t   r;
    logic        active;
    longint      d;
    longint      diff;
    longint      wv;
    logic [63:0] mag;
    logic [63:0] stepv;
    logic [63:0] p;
    active = 1'b1;
    case (w.kind)
      KIND_BLEND: begin
        model_goal = w.target_weight_in;
        model_delay = w.ramp_delay;
      end
      KIND_ASYNC: begin
        if (!model_async) begin
          if (w.mixer_duration == 32'd0) begin
            model_speed = FIX_ONE;
            model_phase = '0;
          end else begin
            model_speed = clip32({16'd0, model_duration, 16'd0} / {32'd0, w.mixer_duration});
            model_phase = clip32(({32'd0, w.unlink_time} * {32'd0, model_speed}) >> 16);
          end
          model_async = 1'b1;
        end
      end
      KIND_TICK: begin
        d = longint'(w.delta_time);
        mag = (d < 0) ? -d : d;
        if ({32'd0, model_delay} <= mag) begin
          model_weight = model_goal;
          model_delay = '0;
          if (model_weight == 16'd0) begin
            active = 1'b0;
          end
        end else begin
          diff = longint'(model_goal) - longint'(model_weight);
          wv = longint'(model_weight) + (d * diff) / longint'(model_delay);
          if (wv < 0) begin
            wv = 0;
          end
          if (wv > 65535) begin
            wv = 65535;
          end
          model_weight = wv[15:0];
          model_delay = clip32(64'(longint'(model_delay) - d));
        end
        if (active && model_async) begin
          stepv = (mag * {32'd0, model_speed}) >> 16;
          p = {32'd0, model_phase};
          if (d >= 0) begin
            p = p + stepv;
          end else begin
            p = (stepv >= p) ? 64'd0 : p - stepv;
          end
          model_phase = clip32(p);
          if (model_phase >= model_duration) begin
            model_phase = (model_duration == 32'd0) ? 32'd0 : model_phase % model_duration;
          end
        end
      end
      default: ;
    endcase
    r.still_active = active;
    r.current_weight = model_weight;
    r.cycle_phase = model_phase;
    r.async_mode = model_async;
    return r;
  endfunction

  function automatic drill_row_t row(logic [1:0] k, logic [15:0] goal, logic [31:0] delay,
                                     logic [31:0] unlink, logic [31:0] mixer,
                                     logic [31:0] delta, bit typed, out_word_t want);
    drill_row_t r;
    r.set_cfg = 1'b0;
    r.cfg_value = '0;
    r.word.kind = k;
    r.word.target_weight_in = goal;
    r.word.ramp_delay = delay;
    r.word.unlink_time = unlink;
    r.word.mixer_duration = mixer;
    r.word.delta_time = delta;
    r.typed = typed;
    r.want = want;
    return r;
  endfunction

  function automatic in_word_t random_word();
    in_word_t    w;
    int unsigned pick;
    w.kind = KIND_TICK;
    w.target_weight_in = 16'($urandom_range(0, 16'hFFFF));
    w.ramp_delay = $urandom;
    w.unlink_time = $urandom;
    w.mixer_duration = $urandom;
    w.delta_time = $urandom;
    pick = $urandom_range(0, 99);
    if (pick < 25) begin
      w.kind = KIND_BLEND;
      case ($urandom_range(0, 7))
        0: w.target_weight_in = 16'h0000;
        1: w.target_weight_in = 16'hFFFF;
        default: ;
      endcase
      case ($urandom_range(0, 3))
        0: w.ramp_delay = $urandom_range(0, 16);
        1: ;
        default: w.ramp_delay = $urandom_range(0, 32'h0008_0000);
      endcase
    end else if (pick < 85) begin
      w.kind = KIND_TICK;
      case ($urandom_range(0, 19))
        0, 1, 2: ;
        3: w.delta_time = 32'h7FFF_FFFF;
        4: w.delta_time = 32'h8000_0000;
        5: w.delta_time = '0;
        6, 7, 8: w.delta_time = $urandom_range(0, 255);
        default: w.delta_time = $urandom_range(0, 32'h0002_0000) - 32'h0001_0000;
      endcase
    end else if (pick < 92) begin
      w.kind = KIND_ASYNC;
    end else begin
      w.kind = KIND_UNUSED;
    end
    return w;
  endfunction

  task automatic drain_reports();
    in_valid <= 1'b0;
    do begin
      @(posedge clk);
    end while (expected_reports.size() != 0);
  endtask

  task automatic write_duration(logic [31:0] value);
    drain_reports();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    model_duration = value;
  endtask

  task automatic sender_gap();
    while ($urandom_range(0, 99) < send_idle_pct) begin
      if (in_valid) begin
        in_valid <= 1'b0;
      end
      @(posedge clk);
    end
  endtask

  task automatic drive(in_word_t w, bit typed, out_word_t want);
    out_word_t predicted;
    in_data <= w;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
    predicted = blend_phase_step(w);
    expected_reports.push_back(typed ? want : predicted);
  endtask

  always @(posedge clk) begin
    out_word_t want;
    if (rst) begin
      out_ready <= 1'b0;
      idle_cycles <= 0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= stall_pct);
      if (out_valid && out_ready) begin
        if (expected_reports.size() == 0) begin
          flag_fault($sformatf("unexpected word: active %0d weight %0d phase %0d async %0d",
                               out_data.still_active, out_data.current_weight,
                               out_data.cycle_phase, out_data.async_mode));
        end else begin
          want = expected_reports.pop_front();
          if (out_data.still_active !== want.still_active ||
              out_data.current_weight !== want.current_weight ||
              out_data.cycle_phase !== want.cycle_phase ||
              out_data.async_mode !== want.async_mode) begin
            flag_fault($sformatf({"mismatch: expected active %0d weight %0d phase %0d async %0d,",
                                  " got active %0d weight %0d phase %0d async %0d"},
                                 want.still_active, want.current_weight, want.cycle_phase,
                                 want.async_mode, out_data.still_active,
                                 out_data.current_weight, out_data.cycle_phase,
                                 out_data.async_mode));
          end
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
        $display("weight_ramp_phase_accumulator_tb: done, errors");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin : stimulus
    drill_row_t  cfg_entry;
    in_word_t    w;
    logic [31:0] async_dur;
    logic [31:0] async_mixer;
    logic [31:0] dur;
    int          counted;

    case ($urandom_range(0, 7))
      0: async_dur = 32'd0;
      1: async_dur = 32'd1;
      2: async_dur = 32'hFFFF_FFFF;
      3: async_dur = DUR_RESET;
      default: async_dur = $urandom_range(1, 32'h0100_0000);
    endcase
    case ($urandom_range(0, 3))
      0: async_mixer = 32'd0;
      1: async_mixer = $urandom;
      default: async_mixer = (async_dur >> 1) + $urandom_range(0, async_dur >> 1);
    endcase

    drills.push_back(row(KIND_TICK, 16'd0, 32'd0, 32'd0, 32'd0, 32'd0, 1'b1,
                         out_word_t'({1'b0, 16'd0, 32'd0, 1'b0})));
    drills.push_back(row(KIND_UNUSED, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                         32'hFFFF_FFFF, 1'b1, out_word_t'({1'b1, 16'd0, 32'd0, 1'b0})));
    drills.push_back(row(KIND_BLEND, 16'hFFFF, 32'd0, 32'd0, 32'd0, 32'd0, 1'b1,
                         out_word_t'({1'b1, 16'd0, 32'd0, 1'b0})));
    drills.push_back(row(KIND_TICK, 16'd0, 32'd0, 32'd0, 32'd0, 32'd0, 1'b1,
                         out_word_t'({1'b1, 16'hFFFF, 32'd0, 1'b0})));
    drills.push_back(row(KIND_BLEND, 16'd0, 32'd4, 32'd0, 32'd0, 32'd0, 1'b1,
                         out_word_t'({1'b1, 16'hFFFF, 32'd0, 1'b0})));
    drills.push_back(row(KIND_TICK, 16'd0, 32'd0, 32'd0, 32'd0, 32'hFFFF_FFFD, 1'b1,
                         out_word_t'({1'b1, 16'hFFFF, 32'd0, 1'b0})));
    drills.push_back(row(KIND_BLEND, 16'd0, 32'h0001_0000, 32'd0, 32'd0, 32'd0, 1'b0, '0));
    drills.push_back(row(KIND_TICK, 16'd0, 32'd0, 32'd0, 32'd0, 32'h0000_8000, 1'b0, '0));
    drills.push_back(row(KIND_TICK, 16'd0, 32'd0, 32'd0, 32'd0, 32'hFFFF_8000, 1'b0, '0));
    drills.push_back(row(KIND_BLEND, 16'hFFFF, 32'hFFFF_FFFF, 32'd0, 32'd0, 32'd0, 1'b0, '0));
    drills.push_back(row(KIND_TICK, 16'd0, 32'd0, 32'd0, 32'd0, 32'h8000_0000, 1'b0, '0));
    drills.push_back(row(KIND_TICK, 16'd0, 32'd0, 32'd0, 32'd0, 32'h7FFF_FFFF, 1'b0, '0));
    drills.push_back(row(KIND_BLEND, 16'h1234, 32'd2, 32'd0, 32'd0, 32'd0, 1'b0, '0));
    drills.push_back(row(KIND_TICK, 16'd0, 32'd0, 32'd0, 32'd0, 32'd1, 1'b0, '0));
    drills.push_back(row(KIND_TICK, 16'd0, 32'd0, 32'd0, 32'd0, 32'hFFFF_FFFF, 1'b0, '0));
    drills.push_back(row(KIND_TICK, 16'd0, 32'd0, 32'd0, 32'd0, 32'd0, 1'b0, '0));
    cfg_entry = row(KIND_UNUSED, 16'd0, 32'd0, 32'd0, 32'd0, 32'd0, 1'b0, '0);
    cfg_entry.set_cfg = 1'b1;
    cfg_entry.cfg_value = async_dur;
    drills.push_back(cfg_entry);
    drills.push_back(row(KIND_ASYNC, 16'd0, 32'd0, $urandom, async_mixer, 32'd0, 1'b0, '0));
    drills.push_back(row(KIND_ASYNC, 16'd0, 32'd0, 32'hFFFF_FFFF, 32'd1, 32'd0, 1'b0, '0));
    drills.push_back(row(KIND_BLEND, 16'hFFFF, 32'd0, 32'd0, 32'd0, 32'd0, 1'b0, '0));
    drills.push_back(row(KIND_TICK, 16'd0, 32'd0, 32'd0, 32'd0, 32'd0, 1'b0, '0));
    drills.push_back(row(KIND_TICK, 16'd0, 32'd0, 32'd0, 32'd0, 32'h7FFF_FFFF, 1'b0, '0));
    drills.push_back(row(KIND_TICK, 16'd0, 32'd0, 32'd0, 32'd0, 32'h8000_0000, 1'b0, '0));
    drills.push_back(row(KIND_UNUSED, 16'd0, 32'd0, 32'd0, 32'd0, 32'd0, 1'b0, '0));

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (drills[i]) begin
      if (drills[i].set_cfg) begin
        write_duration(drills[i].cfg_value);
      end else begin
        drive(drills[i].word, drills[i].typed, drills[i].want);
      end
    end

    for (int phase_idx = 0; phase_idx < PHASE_COUNT; phase_idx++) begin
      case (phase_idx % 4)
        0: begin
          send_idle_pct = 0;
          stall_pct = 0;
        end
        1: begin
          send_idle_pct = 55;
          stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct = 55;
        end
        default: begin
          send_idle_pct = 17;
          stall_pct = 17;
        end
      endcase
      case (phase_idx)
        0: dur = 32'd1;
        1: dur = 32'hFFFF_FFFF;
        2: dur = 32'd0;
        3: dur = DUR_RESET;
        default: dur = $urandom_range(0, 1) ? $urandom_range(1, 32'h0004_0000) : $urandom;
      endcase
      write_duration(dur);
      counted = 0;
      while (counted < WORDS_PER_PHASE) begin
        w = random_word();
        counted++;
        if ($urandom_range(0, 39) == 0) begin
          drain_reports();
        end
        sender_gap();
        drive(w, 1'b0, '0);
      end
    end

    drain_reports();
    repeat (200) @(posedge clk);
    if (expected_reports.size() != 0) begin
      flag_fault($sformatf("%0d words never arrived", expected_reports.size()));
    end
    if (fault_count == 0) begin
      $display("weight_ramp_phase_accumulator_tb: done, clean");
    end else begin
      $display("weight_ramp_phase_accumulator_tb: done, errors");
    end
    $finish;
  end

endmodule
